// ===== sv/cae_pkg.sv =====
// Shared definitions for the 6502-style execute unit: operation codes,
// status flag bit positions and the register-file / result structs.
// No dependencies.
package cae_pkg;

    localparam int OP_W = 6;

    localparam logic [OP_W-1:0] OP_ORA = 6'd0;
    localparam logic [OP_W-1:0] OP_AND = 6'd1;
    localparam logic [OP_W-1:0] OP_EOR = 6'd2;
    localparam logic [OP_W-1:0] OP_ADC = 6'd3;
    localparam logic [OP_W-1:0] OP_SBC = 6'd4;
    localparam logic [OP_W-1:0] OP_CMP = 6'd5;
    localparam logic [OP_W-1:0] OP_CPX = 6'd6;
    localparam logic [OP_W-1:0] OP_CPY = 6'd7;
    localparam logic [OP_W-1:0] OP_BIT = 6'd8;
    localparam logic [OP_W-1:0] OP_LDA = 6'd9;
    localparam logic [OP_W-1:0] OP_LDX = 6'd10;
    localparam logic [OP_W-1:0] OP_LDY = 6'd11;
    localparam logic [OP_W-1:0] OP_STA = 6'd12;
    localparam logic [OP_W-1:0] OP_ASL = 6'd13;
    localparam logic [OP_W-1:0] OP_ROL = 6'd14;
    localparam logic [OP_W-1:0] OP_LSR = 6'd15;
    localparam logic [OP_W-1:0] OP_ROR = 6'd16;
    localparam logic [OP_W-1:0] OP_INC = 6'd17;
    localparam logic [OP_W-1:0] OP_DEC = 6'd18;
    localparam logic [OP_W-1:0] OP_INX = 6'd19;
    localparam logic [OP_W-1:0] OP_INY = 6'd20;
    localparam logic [OP_W-1:0] OP_DEX = 6'd21;
    localparam logic [OP_W-1:0] OP_DEY = 6'd22;
    localparam logic [OP_W-1:0] OP_CLC = 6'd23;
    localparam logic [OP_W-1:0] OP_CLD = 6'd24;
    localparam logic [OP_W-1:0] OP_CLI = 6'd25;
    localparam logic [OP_W-1:0] OP_CLV = 6'd26;
    localparam logic [OP_W-1:0] OP_BCC = 6'd27;
    localparam logic [OP_W-1:0] OP_BCS = 6'd28;
    localparam logic [OP_W-1:0] OP_BEQ = 6'd29;
    localparam logic [OP_W-1:0] OP_BMI = 6'd30;
    localparam logic [OP_W-1:0] OP_BNE = 6'd31;
    localparam logic [OP_W-1:0] OP_BPL = 6'd32;
    localparam logic [OP_W-1:0] OP_BVC = 6'd33;
    localparam logic [OP_W-1:0] OP_BVS = 6'd34;

    // status byte: N V 1 B D I Z C
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] STATUS_RESET = 8'h24;

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
    } cae_regs_t;

    typedef struct packed {
        cae_regs_t  regs;
        logic [7:0] store_data;
        logic       store_en;
        logic       taken;
    } cae_result_t;

endpackage

// ===== sv/cae_exec.sv =====
// Combinational execute step: one instruction against the register file.
// Produces the updated registers, store byte/enable and branch decision.
// Depends on cae_pkg.
module cae_exec
    import cae_pkg::*;
(
    input  logic [OP_W-1:0] op,
    input  logic [7:0]      operand,
    input  logic            to_accumulator,
    input  logic            decimal_enable,
    input  cae_regs_t       regs,
    output cae_result_t     result
);

    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] nm;
    logic       cin;
    logic       bcd;

    logic [8:0] adc_bin;
    logic [8:0] sbc_bin;
    logic [4:0] adc_lo_raw;
    logic [4:0] adc_lo;
    logic [8:0] adc_sum;
    logic [9:0] adc_adj;

    logic signed [5:0] sbc_lo_raw;
    logic signed [5:0] sbc_lo_m6;
    logic signed [5:0] sbc_lo;
    logic signed [9:0] sbc_res;
    logic signed [9:0] sbc_adj;

    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [7:0] sh_in;
    logic [7:0] sh_out;
    logic       sh_carry;
    logic [7:0] inc_dec;
    logic       br_bit;

    always_comb begin
        a   = regs.acc;
        m   = operand;
        nm  = ~operand;
        cin = regs.p[FLAG_C];
        bcd = decimal_enable & regs.p[FLAG_D];

        adc_bin = {1'b0, a} + {1'b0, m} + {8'b0, cin};
        sbc_bin = {1'b0, a} + {1'b0, nm} + {8'b0, cin};

        // decimal add: low digit then high digit
        adc_lo_raw = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, cin};
        if (adc_lo_raw >= 5'd10) begin
            adc_lo = {1'b1, 4'(adc_lo_raw[3:0] + 4'd6)};
        end else begin
            adc_lo = adc_lo_raw;
        end
        adc_sum = {1'b0, a[7:4], 4'b0} + {1'b0, m[7:4], 4'b0} + {4'b0, adc_lo};
        if (adc_sum >= 9'h0A0) begin
            adc_adj = {1'b0, adc_sum} + 10'h060;
        end else begin
            adc_adj = {1'b0, adc_sum};
        end

        // decimal subtract: only the accumulator value is adjusted
        sbc_lo_raw = $signed({2'b00, a[3:0]}) - $signed({2'b00, m[3:0]})
                   + $signed({5'b0, cin}) - 6'sd1;
        sbc_lo_m6  = sbc_lo_raw - 6'sd6;
        if (sbc_lo_raw[5]) begin
            sbc_lo = $signed({2'b11, sbc_lo_m6[3:0]});
        end else begin
            sbc_lo = sbc_lo_raw;
        end
        sbc_res = $signed({2'b00, a[7:4], 4'b0}) - $signed({2'b00, m[7:4], 4'b0})
                + 10'(sbc_lo);
        if (sbc_res[9]) begin
            sbc_adj = sbc_res - 10'sd96;
        end else begin
            sbc_adj = sbc_res;
        end

        case (op)
            OP_CPX:  cmp_reg = regs.x;
            OP_CPY:  cmp_reg = regs.y;
            default: cmp_reg = regs.acc;
        endcase
        cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

        sh_in = to_accumulator ? a : m;
        case (op)
            OP_ASL: begin
                sh_out   = {sh_in[6:0], 1'b0};
                sh_carry = sh_in[7];
            end
            OP_ROL: begin
                sh_out   = {sh_in[6:0], cin};
                sh_carry = sh_in[7];
            end
            OP_ROR: begin
                sh_out   = {cin, sh_in[7:1]};
                sh_carry = sh_in[0];
            end
            default: begin
                sh_out   = {1'b0, sh_in[7:1]};
                sh_carry = sh_in[0];
            end
        endcase

        inc_dec = (op == OP_DEC) ? m - 8'd1 : m + 8'd1;

        case (op)
            OP_BCC, OP_BCS: br_bit = regs.p[FLAG_C];
            OP_BEQ, OP_BNE: br_bit = regs.p[FLAG_Z];
            OP_BMI, OP_BPL: br_bit = regs.p[FLAG_N];
            default:        br_bit = regs.p[FLAG_V];
        endcase

        result            = '0;
        result.regs       = regs;

        case (op)
            OP_ORA, OP_AND, OP_EOR: begin
                if (op == OP_ORA) begin
                    result.regs.acc = a | m;
                end else if (op == OP_AND) begin
                    result.regs.acc = a & m;
                end else begin
                    result.regs.acc = a ^ m;
                end
                result.regs.p[FLAG_N] = result.regs.acc[7];
                result.regs.p[FLAG_Z] = (result.regs.acc == 8'h00);
            end
            OP_ADC: begin
                if (bcd) begin
                    result.regs.acc       = adc_adj[7:0];
                    result.regs.p[FLAG_N] = adc_sum[7];
                    result.regs.p[FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ adc_sum[7]);
                    result.regs.p[FLAG_Z] = (adc_bin[7:0] == 8'h00);
                    result.regs.p[FLAG_C] = (adc_adj >= 10'h100);
                end else begin
                    result.regs.acc       = adc_bin[7:0];
                    result.regs.p[FLAG_N] = adc_bin[7];
                    result.regs.p[FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ adc_bin[7]);
                    result.regs.p[FLAG_Z] = (adc_bin[7:0] == 8'h00);
                    result.regs.p[FLAG_C] = adc_bin[8];
                end
            end
            OP_SBC: begin
                result.regs.acc       = bcd ? sbc_adj[7:0] : sbc_bin[7:0];
                result.regs.p[FLAG_N] = sbc_bin[7];
                result.regs.p[FLAG_V] = ~(a[7] ^ nm[7]) & (a[7] ^ sbc_bin[7]);
                result.regs.p[FLAG_Z] = (sbc_bin[7:0] == 8'h00);
                result.regs.p[FLAG_C] = sbc_bin[8];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                result.regs.p[FLAG_N] = cmp_diff[7];
                result.regs.p[FLAG_Z] = (cmp_diff[7:0] == 8'h00);
                result.regs.p[FLAG_C] = ~cmp_diff[8];
            end
            OP_BIT: begin
                result.regs.p[FLAG_Z] = ((a & m) == 8'h00);
                result.regs.p[FLAG_N] = m[7];
                result.regs.p[FLAG_V] = m[6];
            end
            OP_LDA, OP_LDX, OP_LDY: begin
                if (op == OP_LDA) begin
                    result.regs.acc = m;
                end else if (op == OP_LDX) begin
                    result.regs.x = m;
                end else begin
                    result.regs.y = m;
                end
                result.regs.p[FLAG_N] = m[7];
                result.regs.p[FLAG_Z] = (m == 8'h00);
            end
            OP_STA: begin
                result.store_data = a;
                result.store_en   = 1'b1;
            end
            OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
                result.regs.p[FLAG_C] = sh_carry;
                result.regs.p[FLAG_N] = sh_out[7];
                result.regs.p[FLAG_Z] = (sh_out == 8'h00);
                if (to_accumulator) begin
                    result.regs.acc = sh_out;
                end else begin
                    result.store_data = sh_out;
                    result.store_en   = 1'b1;
                end
            end
            OP_INC, OP_DEC: begin
                result.store_data     = inc_dec;
                result.store_en       = 1'b1;
                result.regs.p[FLAG_N] = inc_dec[7];
                result.regs.p[FLAG_Z] = (inc_dec == 8'h00);
            end
            OP_INX, OP_DEX: begin
                result.regs.x = (op == OP_INX) ? regs.x + 8'd1 : regs.x - 8'd1;
                result.regs.p[FLAG_N] = result.regs.x[7];
                result.regs.p[FLAG_Z] = (result.regs.x == 8'h00);
            end
            OP_INY, OP_DEY: begin
                result.regs.y = (op == OP_INY) ? regs.y + 8'd1 : regs.y - 8'd1;
                result.regs.p[FLAG_N] = result.regs.y[7];
                result.regs.p[FLAG_Z] = (result.regs.y == 8'h00);
            end
            OP_CLC: result.regs.p[FLAG_C] = 1'b0;
            OP_CLD: result.regs.p[FLAG_D] = 1'b0;
            OP_CLI: result.regs.p[FLAG_I] = 1'b0;
            OP_CLV: result.regs.p[FLAG_V] = 1'b0;
            default: begin
                // branches: the set-testing ones are BCS BEQ BMI BVS
                if (op inside {[OP_BCC:OP_BVS]}) begin
                    if (op inside {OP_BCS, OP_BEQ, OP_BMI, OP_BVS}) begin
                        result.taken = br_bit;
                    end else begin
                        result.taken = ~br_bit;
                    end
                end
            end
        endcase
    end

endmodule

// ===== sv/cpu_alu_and_flags_execute.sv =====
// Top level of the 6502-style execute unit: input register, register file,
// decimal-enable register and result register around cae_exec.
// Depends on cae_pkg and cae_exec.
//
// Usage
//   s_ channel: one instruction per transaction. s_tdata = {operand, op},
//   s_tuser = to_accumulator. m_ channel: one result per instruction with the
//   A/X/Y/status registers after it, the store byte and the branch decision;
//   m_tuser carries the store enable.
//   cfg_we/cfg_wdata write decimal_enable; write it only while no instruction
//   is in flight.
//   Path: each instruction goes through the input register, then the result
//   register loaded by the single execute pass, before its result transaction.
//   Throughput: 1 instruction per cycle while the result side is ready; the
//   register file is updated in the same cycle that the execute pass reads it,
//   so dependent instructions follow back to back.
//   Stall: when m_tready is low the result register holds; one more
//   instruction waits in the input register, then s_tready drops.
//   Reset: aresetn low (synchronous) empties both stages, clears A, X and Y,
//   sets status to 0x24 and decimal_enable to 1.
module cpu_alu_and_flags_execute
    import cae_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic                 cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] op, [13:6] operand, [15:14] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] to_accumulator
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] acc_out, [15:8] x_out, [23:16] y_out, [31:24] flags_out,
    // [39:32] store_data, [40] branch_taken, [47:41] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] store_enable
    output logic                 m_tuser
);

    logic            in_valid_reg, in_valid_next;
    logic [OP_W-1:0] in_op_reg;
    logic [7:0]      in_operand_reg;
    logic            in_to_acc_reg;

    logic            out_valid_reg, out_valid_next;
    cae_result_t     out_reg;

    cae_regs_t       regs_reg;
    logic            dec_en_reg;

    cae_result_t     exec_result;
    logic            s_accept;
    logic            advance;

    cae_exec u_exec (
        .op             (in_op_reg),
        .operand        (in_operand_reg),
        .to_accumulator (in_to_acc_reg),
        .decimal_enable (dec_en_reg),
        .regs           (regs_reg),
        .result         (exec_result)
    );

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            regs_reg      <= '{acc: 8'h00, x: 8'h00, y: 8'h00, p: STATUS_RESET};
            dec_en_reg    <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                regs_reg <= exec_result.regs;
            end
            if (cfg_we) begin
                dec_en_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg      <= s_tdata[OP_W-1:0];
            in_operand_reg <= s_tdata[OP_W+7:OP_W];
            in_to_acc_reg  <= s_tuser;
        end
        if (advance) begin
            out_reg <= exec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.taken, out_reg.store_data, out_reg.regs.p,
                       out_reg.regs.y, out_reg.regs.x, out_reg.regs.acc};
    assign m_tuser  = out_reg.store_en;

endmodule

// ===== sv/cae_checker.sv =====
// Port-level checks for the execute unit, attached to the top level by bind.
// Depends on cae_pkg.
module cae_checker
    import cae_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // nothing stored means a zero store byte, and a store never also branches
    a_store_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser || m_tdata[39:32] == 8'h00) && !(m_tuser && m_tdata[40]))
        else $error("store byte or branch flag inconsistent");

    // fixed status bits 5 and 4 never move
    a_fixed_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[29:28] == STATUS_RESET[5:4])
        else $error("fixed status bits changed");

    // a ready result side never blocks the input
    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while result side ready");

endmodule

bind cpu_alu_and_flags_execute cae_checker u_cae_checker (.*);

// ===== tb/cpu_alu_and_flags_execute_tb.sv =====
// Self-checking testbench for cpu_alu_and_flags_execute: an instruction-level
// model of the 6502 ALU, register file and flags predicts every result.
// Depends on cae_pkg and the RTL of the execute unit.
`timescale 1ns / 100ps

module cpu_alu_and_flags_execute_tb
    import cae_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int unsigned LONG_HOLD = 80;
    localparam logic [OP_W-1:0] OP_UNUSED_TOP = 6'd63;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 6'd35;

    // Predicts register file, flags, store and branch for each instruction
    // and checks the results in order.
    class alu_scoreboard;
        logic [7:0] acc, xr, yr, status;
        logic dec_en;
        cae_result_t outcomes_due[$];
        int unsigned errors;

        function new();
            acc = 8'h00;
            xr = 8'h00;
            yr = 8'h00;
            status = STATUS_RESET;
            dec_en = 1'b1;
            errors = 0;
        endfunction

        function void set_nz(logic [7:0] v);
            status[FLAG_N] = v[7];
            status[FLAG_Z] = (v == 8'h00);
        endfunction

        function void compare_to(logic [7:0] r, logic [7:0] m);
            set_nz(r - m);
            status[FLAG_C] = (r >= m);
        endfunction

        function void note_instruction(logic [OP_W-1:0] op, logic [7:0] m, logic to_acc);
            cae_result_t res;
            logic [8:0] bin;
            logic [7:0] nm, v, r;
            logic cin;
            int lo, sum;
            res = '0;
            cin = status[FLAG_C];
            case (op)
                OP_ORA: begin acc = acc | m; set_nz(acc); end
                OP_AND: begin acc = acc & m; set_nz(acc); end
                OP_EOR: begin acc = acc ^ m; set_nz(acc); end
                OP_ADC: begin
                    bin = {1'b0, acc} + {1'b0, m} + {8'h00, cin};
                    if (!(dec_en && status[FLAG_D])) begin
                        set_nz(bin[7:0]);
                        status[FLAG_C] = bin[8];
                        status[FLAG_V] = ~(acc[7] ^ m[7]) & (acc[7] ^ bin[7]);
                        acc = bin[7:0];
                    end else begin
                        // BCD: N and V taken between the low and high digit fix-ups
                        lo = int'(acc[3:0]) + int'(m[3:0]) + int'(cin);
                        if (lo >= 10) lo = ((lo + 6) & 15) + 16;
                        sum = int'(acc & 8'hF0) + int'(m & 8'hF0) + lo;
                        status[FLAG_N] = sum[7];
                        status[FLAG_V] = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
                        status[FLAG_Z] = (bin[7:0] == 8'h00);
                        if (sum >= 'hA0) sum = sum + 'h60;
                        status[FLAG_C] = (sum >= 'h100);
                        acc = sum[7:0];
                    end
                end
                OP_SBC: begin
                    nm = ~m;
                    bin = {1'b0, acc} + {1'b0, nm} + {8'h00, cin};
                    set_nz(bin[7:0]);
                    status[FLAG_C] = bin[8];
                    status[FLAG_V] = ~(acc[7] ^ nm[7]) & (acc[7] ^ bin[7]);
                    if (!(dec_en && status[FLAG_D])) begin
                        acc = bin[7:0];
                    end else begin
                        // flags stay binary, only A is adjusted
                        lo = int'(acc[3:0]) - int'(m[3:0]) + int'(cin) - 1;
                        if (lo < 0) lo = ((lo - 6) & 15) - 16;
                        sum = int'(acc & 8'hF0) - int'(m & 8'hF0) + lo;
                        if (sum < 0) sum = sum - 'h60;
                        acc = sum[7:0];
                    end
                end
                OP_CMP: compare_to(acc, m);
                OP_CPX: compare_to(xr, m);
                OP_CPY: compare_to(yr, m);
                OP_BIT: begin
                    status[FLAG_Z] = ((acc & m) == 8'h00);
                    status[FLAG_N] = m[7];
                    status[FLAG_V] = m[6];
                end
                OP_LDA: begin acc = m; set_nz(m); end
                OP_LDX: begin xr = m; set_nz(m); end
                OP_LDY: begin yr = m; set_nz(m); end
                OP_STA: begin res.store_data = acc; res.store_en = 1'b1; end
                OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
                    v = to_acc ? acc : m;
                    if (op == OP_ASL || op == OP_ROL) begin
                        r = {v[6:0], (op == OP_ROL) ? cin : 1'b0};
                        status[FLAG_C] = v[7];
                    end else begin
                        r = {(op == OP_ROR) ? cin : 1'b0, v[7:1]};
                        status[FLAG_C] = v[0];
                    end
                    set_nz(r);
                    if (to_acc) begin
                        acc = r;
                    end else begin
                        res.store_data = r;
                        res.store_en = 1'b1;
                    end
                end
                OP_INC: begin
                    res.store_data = m + 8'd1;
                    res.store_en = 1'b1;
                    set_nz(res.store_data);
                end
                OP_DEC: begin
                    res.store_data = m - 8'd1;
                    res.store_en = 1'b1;
                    set_nz(res.store_data);
                end
                OP_INX: begin xr = xr + 8'd1; set_nz(xr); end
                OP_INY: begin yr = yr + 8'd1; set_nz(yr); end
                OP_DEX: begin xr = xr - 8'd1; set_nz(xr); end
                OP_DEY: begin yr = yr - 8'd1; set_nz(yr); end
                OP_CLC: status[FLAG_C] = 1'b0;
                OP_CLD: status[FLAG_D] = 1'b0;
                OP_CLI: status[FLAG_I] = 1'b0;
                OP_CLV: status[FLAG_V] = 1'b0;
                OP_BCC: res.taken = ~status[FLAG_C];
                OP_BCS: res.taken = status[FLAG_C];
                OP_BEQ: res.taken = status[FLAG_Z];
                OP_BMI: res.taken = status[FLAG_N];
                OP_BNE: res.taken = ~status[FLAG_Z];
                OP_BPL: res.taken = ~status[FLAG_N];
                OP_BVC: res.taken = ~status[FLAG_V];
                OP_BVS: res.taken = status[FLAG_V];
                default: ; // unused codes change nothing
            endcase
            res.regs.acc = acc;
            res.regs.x = xr;
            res.regs.y = yr;
            res.regs.p = status;
            outcomes_due.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d, logic st_en);
            cae_result_t want, got;
            got.regs.acc = d[7:0];
            got.regs.x = d[15:8];
            got.regs.y = d[23:16];
            got.regs.p = d[31:24];
            got.store_data = d[39:32];
            got.taken = d[40];
            got.store_en = st_en;
            if (outcomes_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] result transaction with no instruction outstanding", $time);
                return;
            end
            want = outcomes_due.pop_front();
            if (got.regs.acc !== want.regs.acc || got.regs.x !== want.regs.x ||
                got.regs.y !== want.regs.y || got.regs.p !== want.regs.p ||
                got.store_data !== want.store_data || got.store_en !== want.store_en ||
                got.taken !== want.taken) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch: exp A=%h X=%h Y=%h P=%h st=%h/%b br=%b, got A=%h X=%h Y=%h P=%h st=%h/%b br=%b",
                             $time, want.regs.acc, want.regs.x, want.regs.y, want.regs.p,
                             want.store_data, want.store_en, want.taken,
                             got.regs.acc, got.regs.x, got.regs.y, got.regs.p,
                             got.store_data, got.store_en, got.taken);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    alu_scoreboard sb;
    bit tx_gaps;
    bit rx_stalls;
    bit hold_pending;
    int unsigned cycle_count;

    cpu_alu_and_flags_execute uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random back-pressure plus one long hold on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap() - 1;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("cpu_alu_and_flags_execute verification failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_instr(logic [OP_W-1:0] op, logic [7:0] operand, logic to_acc);
        int unsigned gap;
        gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {2'b00, operand, op};
        s_tuser = to_acc;
        do @(posedge aclk); while (!s_tready);
        sb.note_instruction(op, operand, to_acc);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.outcomes_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_decimal_enable(logic v);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.dec_en = v;
    endtask

    task automatic send_random(int unsigned count);
        logic [OP_W-1:0] op;
        logic [7:0] operand;
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 90) op = OP_W'($urandom_range(OP_ORA, OP_BVS));
            else op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_TOP));
            case ($urandom_range(0, 9))
                0: operand = 8'h00;
                1: operand = 8'hFF;
                2: operand = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {7{$urandom_range(0, 1) == 1}}};
                default: operand = 8'($urandom_range(0, 255));
            endcase
            send_instr(op, operand, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        sb = new();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_pending = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        write_decimal_enable(1'b0);

        // directed: overflow, borrow, compares, BIT, shifts both ways, wrap-round
        send_instr(OP_LDA, 8'h7F, 1'b0);
        send_instr(OP_ADC, 8'h01, 1'b0);
        send_instr(OP_SBC, 8'h01, 1'b0);
        send_instr(OP_CMP, 8'h7E, 1'b0);
        send_instr(OP_CPX, 8'hFF, 1'b0);
        send_instr(OP_CPY, 8'h00, 1'b0);
        send_instr(OP_BIT, 8'hC0, 1'b0);
        send_instr(OP_BVS, 8'h00, 1'b0);
        send_instr(OP_BMI, 8'h00, 1'b0);
        send_instr(OP_CLV, 8'h00, 1'b0);
        send_instr(OP_BVC, 8'h00, 1'b0);
        send_instr(OP_ORA, 8'h80, 1'b0);
        send_instr(OP_AND, 8'h0F, 1'b0);
        send_instr(OP_EOR, 8'hFF, 1'b0);
        send_instr(OP_STA, 8'h00, 1'b1);
        send_instr(OP_ASL, 8'h00, 1'b1);
        send_instr(OP_ROL, 8'h80, 1'b0);
        send_instr(OP_LSR, 8'h01, 1'b0);
        send_instr(OP_ROR, 8'h00, 1'b1);
        send_instr(OP_INC, 8'hFF, 1'b0);
        send_instr(OP_DEC, 8'h00, 1'b0);
        send_instr(OP_DEX, 8'h00, 1'b0);
        send_instr(OP_LDA, 8'hFF, 1'b0);
        send_instr(OP_ADC, 8'hFF, 1'b0);
        send_instr(OP_UNUSED_TOP, 8'hA5, 1'b1);

        // back to back, no idling on either side
        write_decimal_enable(1'b1);
        send_random(200);

        // long result hold-off while instructions keep arriving
        write_decimal_enable(1'b0);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        hold_pending = 1'b1;
        send_random(350);

        write_decimal_enable(1'b1);
        send_random(400);

        drain();
        repeat (6) @(negedge aclk);
        if (sb.errors == 0 && sb.outcomes_due.size() == 0) begin
            $display("cpu_alu_and_flags_execute verification clean");
        end else begin
            $display("cpu_alu_and_flags_execute verification failed");
        end
        $finish;
    end

endmodule
